// ===== src/lsfh_pkg.sv =====
// Package for the LIN slave frame handler: codes, widths and shared types.
// Used by every module of the block but lsfh_ram; depends on nothing.
package lsfh_pkg;

  localparam int TableDepth   = 16;
  localparam int MaxDataBytes = 8;

  localparam logic [7:0] SyncByte = 8'h55;

  localparam logic [1:0] OpRxByte = 2'd0;
  localparam logic [1:0] OpTick   = 2'd1;
  localparam logic [1:0] OpWrite  = 2'd2;
  localparam logic [1:0] OpRead   = 2'd3;

  localparam logic [1:0] KindStatus = 2'd0;
  localparam logic [1:0] KindTx     = 2'd1;
  localparam logic [1:0] KindRead   = 2'd2;

  localparam logic [2:0] StProcessing = 3'd0;
  localparam logic [2:0] StValid      = 3'd1;
  localparam logic [2:0] StReplied    = 3'd2;
  localparam logic [2:0] StBadCksum   = 3'd3;
  localparam logic [2:0] StTimeout    = 3'd4;
  localparam logic [2:0] StNoMatch    = 3'd5;
  localparam logic [2:0] StSyncError  = 3'd6;

  localparam logic [1:0] RegMaxTime  = 2'd0;
  localparam logic [1:0] RegEntries  = 2'd1;
  localparam logic [1:0] RegCksmMode = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [19:0] elapsed_us;
    logic [3:0]  entry_index;
    logic [7:0]  entry_pid;
    logic [3:0]  entry_len;
    logic        entry_sends;
    logic [63:0] entry_payload;
  } item_t;

  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage

// ===== src/lin_slave_frame_handler.sv =====
// Top level of the LIN slave frame handler: register port, front queue, back end.
// Depends on lsfh_pkg, lsfh_front and lsfh_back.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | opcode .. entry_payload
//   out     | output    | out_valid/out_stall| kind .. got_checksum
//   apb     | input     | psel/penable/pready| three registers at 4*i
//
// A tick, a sync or checksum byte and a table write are done in the idle state; a data byte
// also passes SData, a table read SRdWt. An identifier byte steps through the entries in use
// up to the match, or past the last when none matches; a send frame then fetches the payload
// and gives one result per cycle while the output is not stalled.
// Reset is asynchronous and clears control only; the table holds nothing until written.
// Output stalls hold the result register and back up through the two-entry queue.
module lin_slave_frame_handler #(
  parameter int MaxDataBytes = lsfh_pkg::MaxDataBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [19:0] elapsed_us_i,
  input  logic [3:0]  entry_index_i,
  input  logic [7:0]  entry_pid_i,
  input  logic [3:0]  entry_len_i,
  input  logic        entry_sends_i,
  input  logic [63:0] entry_payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  status_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [3:0]  hit_index_o,
  output logic [63:0] read_payload_o,
  output logic [7:0]  got_checksum_o
);

  logic [19:0] max_time_q;
  logic [4:0]  entries_q;
  logic        cmode_q;
  logic [1:0]  reg_idx;
  logic        q_valid, q_pop;
  lsfh_pkg::item_t in_item, q_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_time_q <= 20'hFFFFF;
      entries_q  <= 5'd0;
      cmode_q    <= 1'b1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      unique case (reg_idx)
        lsfh_pkg::RegMaxTime:  max_time_q <= pwdata[19:0];
        lsfh_pkg::RegEntries:  entries_q  <= pwdata[4:0];
        lsfh_pkg::RegCksmMode: cmode_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lsfh_pkg::RegMaxTime:  prdata = {12'd0, max_time_q};
      lsfh_pkg::RegEntries:  prdata = {27'd0, entries_q};
      lsfh_pkg::RegCksmMode: prdata = {31'd0, cmode_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign in_item = '{opcode: opcode_i, rx_byte: rx_byte_i, elapsed_us: elapsed_us_i,
                     entry_index: entry_index_i, entry_pid: entry_pid_i,
                     entry_len: entry_len_i, entry_sends: entry_sends_i,
                     entry_payload: entry_payload_i};

  lsfh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  lsfh_back #(.MaxDataBytes(MaxDataBytes)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_item_i         (q_item),
    .max_frame_time_i (max_time_q),
    .entries_in_use_i (entries_q),
    .checksum_mode_i  (cmode_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .status_o         (status_o),
    .tx_byte_o        (tx_byte_o),
    .last_o           (last_o),
    .hit_index_o      (hit_index_o),
    .read_payload_o   (read_payload_o),
    .got_checksum_o   (got_checksum_o)
  );

endmodule

// ===== src/lsfh_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// Stand-alone; used for the frame table payload store.
module lsfh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/lsfh_front.sv =====
// Front end: a two-entry queue towards the back end.
// Depends on lsfh_pkg.
module lsfh_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lsfh_pkg::item_t  in_item_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output lsfh_pkg::item_t  q_item_o
);

  lsfh_pkg::item_t slot_q [2];
  logic            rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = !rd_ptr_q;
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ===== src/lsfh_back.sv =====
// Back end: frame sequencer, frame table, identifier search and result register.
// Depends on lsfh_pkg and lsfh_ram.
module lsfh_back #(
  parameter int MaxDataBytes = lsfh_pkg::MaxDataBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  lsfh_pkg::item_t q_item_i,
  input  logic [19:0]     max_frame_time_i,
  input  logic [4:0]      entries_in_use_i,
  input  logic            checksum_mode_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [2:0]      status_o,
  output logic [7:0]      tx_byte_o,
  output logic            last_o,
  output logic [3:0]      hit_index_o,
  output logic [63:0]     read_payload_o,
  output logic [7:0]      got_checksum_o
);

  localparam int TableDepth = lsfh_pkg::TableDepth;
  localparam int Aw = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int Cw = $clog2(TableDepth + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRdWt  = 3'd1;
  localparam logic [2:0] SSrch  = 3'd2;
  localparam logic [2:0] SFetch = 3'd3;
  localparam logic [2:0] SSend  = 3'd4;
  localparam logic [2:0] SData  = 3'd5;

  localparam logic [1:0] PhSync = 2'd0;
  localparam logic [1:0] PhPid  = 2'd1;
  localparam logic [1:0] PhData = 2'd2;
  localparam logic [1:0] PhCksm = 2'd3;

  logic [2:0]  st_q, st_d;
  logic [1:0]  ph_q, ph_d;
  logic [Aw-1:0] cur_q, cur_d;
  logic [3:0]  bcnt_q, bcnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [Cw-1:0] si_q, si_d;
  logic [3:0]  j_q, j_d;

  logic [7:0]  pid_q [TableDepth];
  logic [3:0]  len_q [TableDepth];
  logic        snd_q [TableDepth];

  logic        ov_q, ov_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  stat_q, stat_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic [3:0]  hit_q, hit_d;
  logic [63:0] pay_q, pay_d;
  logic [7:0]  got_q, got_d;
  logic        use_ram_q, use_ram_d;

  logic        ram_we;
  logic [Aw-1:0] ram_wa, ram_ra;
  logic [63:0] ram_wd, ram_rd;

  lsfh_pkg::item_t it;
  logic        out_free, idx_ok;
  logic [Cw-1:0] lim;
  logic [Aw-1:0] idx, si_a;
  logic [3:0]  eff_len;
  logic [7:0]  pbyte;

  lsfh_ram #(.Width(64), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign it       = q_item_i;
  assign out_free = !ov_q || !out_stall_i;
  assign idx      = it.entry_index[Aw-1:0];
  assign idx_ok   = ({28'd0, it.entry_index} < TableDepth);
  assign si_a     = si_q[Aw-1:0];
  assign lim      = ({27'd0, entries_in_use_i} > TableDepth) ? Cw'(TableDepth)
                                                             : Cw'(entries_in_use_i);

  always_comb begin
    eff_len = len_q[cur_q];
    if (eff_len == 4'd0) begin
      eff_len = 4'd1;
    end
    if ({28'd0, eff_len} > MaxDataBytes) begin
      eff_len = 4'(MaxDataBytes);
    end
    pbyte = ram_rd[8*j_q[2:0] +: 8];
  end

  always_comb begin
    st_d = st_q; ph_d = ph_q; cur_d = cur_q; bcnt_d = bcnt_q; sum_d = sum_q;
    si_d = si_q; j_d = j_q;
    ov_d = ov_q && out_stall_i;
    kind_d = kind_q; stat_d = stat_q; tx_d = tx_q; last_d = last_q;
    hit_d = hit_q; pay_d = pay_q; got_d = got_q; use_ram_d = use_ram_q;
    q_pop_o = 1'b0;
    ram_we = 1'b0; ram_wa = idx; ram_wd = it.entry_payload; ram_ra = idx;
    unique case (st_q)
      SIdle: begin
        if (q_valid_i && out_free) begin
          kind_d = lsfh_pkg::KindStatus; stat_d = lsfh_pkg::StProcessing;
          tx_d = 8'd0; last_d = 1'b1; hit_d = 4'd0; pay_d = 64'd0; got_d = 8'd0;
          use_ram_d = 1'b0;
          unique case (it.opcode)
            lsfh_pkg::OpWrite: begin
              q_pop_o = 1'b1;
              ram_we  = idx_ok;
            end
            lsfh_pkg::OpRead: begin
              q_pop_o = 1'b1;
              st_d = SRdWt;
              kind_d = lsfh_pkg::KindRead; hit_d = it.entry_index;
              use_ram_d = idx_ok;
            end
            default: begin
              if (it.elapsed_us > max_frame_time_i) begin
                q_pop_o = 1'b1; ov_d = 1'b1;
                stat_d = lsfh_pkg::StTimeout;
                ph_d = PhSync; bcnt_d = 4'd0; sum_d = 8'd0;
              end else if (it.opcode == lsfh_pkg::OpTick) begin
                q_pop_o = 1'b1; ov_d = 1'b1;
              end else begin
                unique case (ph_q)
                  PhSync: begin
                    q_pop_o = 1'b1; ov_d = 1'b1;
                    if (it.rx_byte == lsfh_pkg::SyncByte) begin
                      ph_d = PhPid;
                    end else begin
                      stat_d = lsfh_pkg::StSyncError;
                      bcnt_d = 4'd0; sum_d = 8'd0;
                    end
                  end
                  PhPid: begin
                    st_d = SSrch; si_d = '0;
                  end
                  PhData: begin
                    ram_ra = cur_q;
                    st_d = SData;
                  end
                  default: begin
                    q_pop_o = 1'b1; ov_d = 1'b1;
                    stat_d = (it.rx_byte == ~sum_q) ? lsfh_pkg::StValid
                                                    : lsfh_pkg::StBadCksum;
                    hit_d = 4'(cur_q); got_d = it.rx_byte;
                    ph_d = PhSync; bcnt_d = 4'd0; sum_d = 8'd0;
                  end
                endcase
              end
            end
          endcase
        end
      end
      SRdWt: begin
        if (use_ram_q) begin
          pay_d = ram_rd;
        end
        ov_d = 1'b1; st_d = SIdle;
      end
      SSrch: begin
        if (si_q >= lim) begin
          q_pop_o = 1'b1; ov_d = 1'b1; st_d = SIdle;
          stat_d = lsfh_pkg::StNoMatch;
          ph_d = PhSync; bcnt_d = 4'd0; sum_d = 8'd0;
        end else if (pid_q[si_a] == it.rx_byte) begin
          cur_d = si_a; bcnt_d = 4'd0;
          sum_d = checksum_mode_i ? it.rx_byte : 8'd0;
          if (snd_q[si_a]) begin
            ram_ra = si_a; j_d = 4'd0; st_d = SFetch;
          end else begin
            q_pop_o = 1'b1; ov_d = 1'b1; st_d = SIdle; ph_d = PhData;
          end
        end else begin
          si_d = si_q + Cw'(1);
        end
      end
      SFetch: begin
        ram_ra = cur_q; st_d = SSend;
      end
      SSend: begin
        ram_ra = cur_q;
        if (out_free) begin
          ov_d = 1'b1; hit_d = 4'(cur_q); last_d = 1'b0;
          kind_d = lsfh_pkg::KindTx; stat_d = lsfh_pkg::StProcessing;
          if (j_q < eff_len) begin
            tx_d = pbyte; sum_d = lsfh_pkg::add_carry(sum_q, pbyte);
            j_d = j_q + 4'd1;
          end else if (j_q == eff_len) begin
            tx_d = ~sum_q; j_d = j_q + 4'd1;
          end else begin
            kind_d = lsfh_pkg::KindStatus; stat_d = lsfh_pkg::StReplied;
            tx_d = 8'd0; last_d = 1'b1;
            q_pop_o = 1'b1; st_d = SIdle;
            ph_d = PhSync; bcnt_d = 4'd0; sum_d = 8'd0;
          end
        end
      end
      SData: begin
        ram_we = 1'b1; ram_wa = cur_q;
        ram_wd = ram_rd;
        ram_wd[8*bcnt_q[2:0] +: 8] = it.rx_byte;
        sum_d = lsfh_pkg::add_carry(sum_q, it.rx_byte);
        bcnt_d = bcnt_q + 4'd1;
        if (bcnt_d >= eff_len) begin
          ph_d = PhCksm;
        end
        q_pop_o = 1'b1; ov_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ph_q <= PhSync; cur_q <= '0; bcnt_q <= 4'd0; sum_q <= 8'd0;
      si_q <= '0; j_q <= 4'd0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; cur_q <= cur_d; bcnt_q <= bcnt_d; sum_q <= sum_d;
      si_q <= si_d; j_q <= j_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; stat_q <= stat_d; tx_q <= tx_d; last_q <= last_d;
    hit_q <= hit_d; pay_q <= pay_d; got_q <= got_d; use_ram_q <= use_ram_d;
    if (st_q == SIdle && q_valid_i && out_free && it.opcode == lsfh_pkg::OpWrite
        && idx_ok) begin
      pid_q[idx] <= it.entry_pid;
      len_q[idx] <= it.entry_len;
      snd_q[idx] <= it.entry_sends;
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign status_o       = stat_q;
  assign tx_byte_o      = tx_q;
  assign last_o         = last_q;
  assign hit_index_o    = hit_q;
  assign read_payload_o = pay_q;
  assign got_checksum_o = got_q;

endmodule

// ===== bench/lsfh_checker.sv =====
// Checker for the LIN slave frame handler: follows the register port and both channels,
// predicts every result from its own copy of the frame state and table, and compares.
// Depends on lsfh_pkg.
module lsfh_checker
  import lsfh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [19:0] elapsed_us_i,
  input  logic [3:0]  entry_index_i,
  input  logic [7:0]  entry_pid_i,
  input  logic [3:0]  entry_len_i,
  input  logic        entry_sends_i,
  input  logic [63:0] entry_payload_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_o,
  input  logic [2:0]  status_o,
  input  logic [7:0]  tx_byte_o,
  input  logic        last_o,
  input  logic [3:0]  hit_index_o,
  input  logic [63:0] read_payload_o,
  input  logic [7:0]  got_checksum_o,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  tx;
    logic        last;
    logic [3:0]  hit;
    logic [63:0] pay;
    logic [7:0]  got;
  } frame_result_t;

  typedef enum logic [1:0] {WaitSync, WaitPid, CollectData, WaitCksm} frame_phase_e;

  frame_result_t awaited_results[$];

  logic [19:0]  max_time;
  logic [4:0]   entries_used;
  logic         enhanced;
  frame_phase_e frame_phase;
  logic [3:0]   cur_entry;
  logic [3:0]   byte_cnt;
  logic [7:0]   cksum;
  logic [7:0]   tbl_pid [TableDepth];
  logic [3:0]   tbl_len [TableDepth];
  logic         tbl_sends [TableDepth];
  logic [63:0]  tbl_pay [TableDepth];

  assign pending = awaited_results.size();

  function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? s[7:0] + 8'd1 : s[7:0];
  endfunction

  function automatic int frame_len(input logic [3:0] e);
    int n;
    n = tbl_len[e];
    if (n < 1) n = 1;
    if (n > MaxDataBytes) n = MaxDataBytes;
    return n;
  endfunction

  task automatic push(input logic [1:0] kind, input logic [2:0] status, input logic [7:0] tx,
                      input logic last, input logic [3:0] hit, input logic [63:0] pay,
                      input logic [7:0] got);
    awaited_results.push_back('{kind, status, tx, last, hit, pay, got});
  endtask

  task automatic restart_frame();
    frame_phase = WaitSync;
    byte_cnt = '0;
    cksum = '0;
  endtask

  task automatic predict(input item_t it);
    int n, hit, j, len;
    logic [7:0] s, b;
    if (it.opcode == OpWrite) begin
      tbl_pid[it.entry_index] = it.entry_pid;
      tbl_len[it.entry_index] = it.entry_len;
      tbl_sends[it.entry_index] = it.entry_sends;
      tbl_pay[it.entry_index] = it.entry_payload;
    end else if (it.opcode == OpRead) begin
      push(KindRead, StProcessing, 8'h00, 1'b1, it.entry_index, tbl_pay[it.entry_index], 8'h00);
    end else if (it.elapsed_us > max_time) begin
      restart_frame();
      push(KindStatus, StTimeout, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
    end else if (it.opcode == OpTick) begin
      push(KindStatus, StProcessing, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
    end else begin
      case (frame_phase)
        WaitSync: begin
          if (it.rx_byte == SyncByte) begin
            frame_phase = WaitPid;
            push(KindStatus, StProcessing, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
          end else begin
            restart_frame();
            push(KindStatus, StSyncError, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
          end
        end
        WaitPid: begin
          n = (entries_used > TableDepth) ? TableDepth : entries_used;
          hit = -1;
          for (j = 0; j < n; j++) begin
            if (hit < 0 && tbl_pid[j] == it.rx_byte) hit = j;
          end
          if (hit < 0) begin
            restart_frame();
            push(KindStatus, StNoMatch, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
          end else begin
            cur_entry = 4'(hit);
            cksum = enhanced ? it.rx_byte : 8'h00;
            byte_cnt = '0;
            if (tbl_sends[hit]) begin
              len = frame_len(4'(hit));
              s = cksum;
              for (j = 0; j < len; j++) begin
                b = tbl_pay[hit][8*j +: 8];
                s = fold_add(s, b);
                push(KindTx, StProcessing, b, 1'b0, 4'(hit), 64'd0, 8'h00);
              end
              push(KindTx, StProcessing, ~s, 1'b0, 4'(hit), 64'd0, 8'h00);
              push(KindStatus, StReplied, 8'h00, 1'b1, 4'(hit), 64'd0, 8'h00);
              restart_frame();
            end else begin
              frame_phase = CollectData;
              push(KindStatus, StProcessing, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
            end
          end
        end
        CollectData: begin
          tbl_pay[cur_entry][8*byte_cnt[2:0] +: 8] = it.rx_byte;
          cksum = fold_add(cksum, it.rx_byte);
          byte_cnt = byte_cnt + 4'd1;
          if (byte_cnt >= frame_len(cur_entry)) frame_phase = WaitCksm;
          push(KindStatus, StProcessing, 8'h00, 1'b1, 4'd0, 64'd0, 8'h00);
        end
        default: begin
          s = ~cksum;
          restart_frame();
          push(KindStatus, (it.rx_byte == s) ? StValid : StBadCksum, 8'h00, 1'b1, cur_entry,
               64'd0, it.rx_byte);
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want, seen;
    if (!rst_ni) begin
      max_time <= 20'hFFFFF;
      entries_used <= 5'd0;
      enhanced <= 1'b1;
      frame_phase = WaitSync;
      cur_entry = '0;
      byte_cnt = '0;
      cksum = '0;
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3:2] == RegMaxTime) max_time <= pwdata[19:0];
        if (paddr[3:2] == RegEntries) entries_used <= pwdata[4:0];
        if (paddr[3:2] == RegCksmMode) enhanced <= pwdata[0];
      end
      if (in_valid_i && !in_stall_o) begin
        predict('{opcode_i, rx_byte_i, elapsed_us_i, entry_index_i, entry_pid_i, entry_len_i,
                  entry_sends_i, entry_payload_i});
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{kind_o, status_o, tx_byte_o, last_o, hit_index_o, read_payload_o,
                 got_checksum_o};
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: kind %0d status %0d tx %02h last %0d hit %0d",
                     seen.kind, seen.status, seen.tx, seen.last, seen.hit);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            if (fail_count < 10) begin
              $display({"mismatch: expected kind %0d status %0d tx %02h last %0d hit %0d",
                        " pay %016h got %02h"},
                       want.kind, want.status, want.tx, want.last, want.hit, want.pay,
                       want.got);
              $display({"          actual   kind %0d status %0d tx %02h last %0d hit %0d",
                        " pay %016h got %02h"},
                       seen.kind, seen.status, seen.tx, seen.last, seen.hit, seen.pay,
                       seen.got);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the LIN slave frame handler bench: clock, reset, register writes and frame traffic.
// Depends on lsfh_pkg, lin_slave_frame_handler and lsfh_checker.
module testbench;
  import lsfh_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  item_t       drv;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  kind_o;
  logic [2:0]  status_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [3:0]  hit_index_o;
  logic [63:0] read_payload_o;
  logic [7:0]  got_checksum_o;
  int          fail_count, pending;

  int          cycles = 0;
  int          sent = 0;
  bit          calm = 0;
  int          stall_burst = 0;
  int          cfg_max, cfg_entries;
  bit          cfg_mode;
  logic [7:0]  sh_pid [TableDepth];
  logic [3:0]  sh_len [TableDepth];
  logic        sh_sends [TableDepth];

  lin_slave_frame_handler dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .opcode_i(drv.opcode), .rx_byte_i(drv.rx_byte), .elapsed_us_i(drv.elapsed_us),
    .entry_index_i(drv.entry_index), .entry_pid_i(drv.entry_pid), .entry_len_i(drv.entry_len),
    .entry_sends_i(drv.entry_sends), .entry_payload_i(drv.entry_payload),
    .out_valid_o, .out_stall_i, .kind_o, .status_o, .tx_byte_o, .last_o, .hit_index_o,
    .read_payload_o, .got_checksum_o
  );

  lsfh_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o,
    .opcode_i(drv.opcode), .rx_byte_i(drv.rx_byte), .elapsed_us_i(drv.elapsed_us),
    .entry_index_i(drv.entry_index), .entry_pid_i(drv.entry_pid), .entry_len_i(drv.entry_len),
    .entry_sends_i(drv.entry_sends), .entry_payload_i(drv.entry_payload),
    .out_valid_o, .out_stall_i, .kind_o, .status_o, .tx_byte_o, .last_o, .hit_index_o,
    .read_payload_o, .got_checksum_o, .fail_count, .pending
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("lin_slave_frame_handler regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (calm || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst > 0) begin
      out_stall_i <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_burst <= $urandom_range(1, 7) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? s[7:0] + 8'd1 : s[7:0];
  endfunction

  function automatic logic [19:0] pick_elapsed();
    if ($urandom_range(0, 9) == 0) return 20'($urandom);
    return 20'($urandom_range(0, cfg_max));
  endfunction

  function automatic item_t base_item(input logic [1:0] op);
    item_t it;
    logic [127:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    it = rnd[$bits(item_t)-1:0];
    it.opcode = op;
    it.elapsed_us = pick_elapsed();
    return it;
  endfunction

  function automatic item_t byte_item(input logic [7:0] c);
    item_t it;
    it = base_item(OpRxByte);
    it.rx_byte = c;
    return it;
  endfunction

  function automatic item_t read_item(input logic [3:0] idx);
    item_t it;
    it = base_item(OpRead);
    it.entry_index = idx;
    return it;
  endfunction

  task automatic xfer(input item_t it);
    in_valid_i <= 1'b1;
    drv <= it;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic put_entry(input logic [3:0] idx, input logic [7:0] pid, input logic [3:0] len,
                           input logic sends, input logic [63:0] pay);
    item_t it;
    it = base_item(OpWrite);
    it.entry_index = idx;
    it.entry_pid = pid;
    it.entry_len = len;
    it.entry_sends = sends;
    it.entry_payload = pay;
    sh_pid[idx] = pid;
    sh_len[idx] = len;
    sh_sends[idx] = sends;
    xfer(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_regs(input int max_t, input int ent, input bit mode);
    drain();
    repeat (40) @(posedge clk_i);
    reg_write(RegMaxTime, max_t);
    reg_write(RegEntries, ent);
    reg_write(RegCksmMode, {31'd0, mode});
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_max = max_t;
    cfg_entries = ent;
    cfg_mode = mode;
    @(posedge clk_i);
  endtask

  task automatic run_frame(input bit force_good);
    int n, k, hit, len;
    logic [7:0] pid, c, sum;
    if (!force_good && $urandom_range(0, 9) == 0) begin
      xfer(byte_item(8'($urandom)));
      return;
    end
    xfer(byte_item(SyncByte));
    n = (cfg_entries > TableDepth) ? TableDepth : cfg_entries;
    if (n == 0 || (!force_good && $urandom_range(0, 7) == 0)) pid = 8'($urandom);
    else pid = sh_pid[$urandom_range(0, n - 1)];
    xfer(byte_item(pid));
    hit = -1;
    for (k = 0; k < n; k++) begin
      if (hit < 0 && sh_pid[k] == pid) hit = k;
    end
    if (hit < 0 || sh_sends[hit]) return;
    len = (sh_len[hit] < 1) ? 1 : (sh_len[hit] > MaxDataBytes) ? MaxDataBytes : sh_len[hit];
    sum = cfg_mode ? pid : 8'h00;
    for (k = 0; k < len; k++) begin
      if (!force_good && $urandom_range(0, 9) == 0) xfer(read_item(4'($urandom)));
      c = 8'($urandom);
      sum = fold_add(sum, c);
      xfer(byte_item(c));
    end
    c = ~sum;
    if (!force_good && $urandom_range(0, 4) == 0) c = c ^ (8'd1 << $urandom_range(0, 7));
    xfer(byte_item(c));
  endtask

  initial begin
    int i, r, rand_start, phase_start, ph;
    item_t it;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    drv = '0;
    cfg_max = 20'hFFFFF;
    cfg_entries = 0;
    cfg_mode = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_regs(20'hFFFFF, TableDepth, 1'b1);
    put_entry(4'd0, 8'h00, 4'd0, 1'b1, 64'd0);
    put_entry(4'd1, 8'hFF, 4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    put_entry(4'd2, 8'h3C, 4'd8, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    for (i = 3; i < TableDepth; i++) begin
      put_entry(4'(i), (i == 5) ? 8'h3C : 8'($urandom), 4'($urandom_range(1, 4)),
                1'($urandom), {$urandom, $urandom});
    end
    xfer(read_item(4'd15));
    it = base_item(OpTick);
    xfer(it);
    xfer(byte_item(8'hAA));
    xfer(byte_item(SyncByte));
    xfer(byte_item(8'h00));
    xfer(byte_item(SyncByte));
    xfer(byte_item(8'h3C));
    run_frame(1'b1);

    // The random part cycles through the register settings, extremes included.
    rand_start = sent;
    phase_start = sent;
    ph = 0;
    while (sent - rand_start < 125) begin
      if (sent - phase_start >= 30) begin
        ph++;
        phase_start = sent;
        case (ph % 5)
          0: set_regs(20'hFFFFF, TableDepth, 1'b1);
          1: set_regs(300, 8, 1'b0);
          2: set_regs(0, TableDepth, 1'b1);
          3: set_regs(20'hFFFFF, 0, 1'b0);
          default: set_regs(5000, TableDepth, 1'b0);
        endcase
      end
      if (ph == 1 && sent - phase_start == 15) drain();
      if (sent - rand_start >= 100) calm = 1'b1;
      r = $urandom_range(0, 9);
      case (r)
        0: xfer(base_item(OpTick));
        1: xfer(read_item(4'($urandom)));
        2: put_entry(4'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                     {$urandom, $urandom});
        3: xfer(byte_item(8'($urandom)));
        default: run_frame(1'b0);
      endcase
    end
    calm = 1'b1;
    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("lin_slave_frame_handler regression: pass");
    end else begin
      $display("lin_slave_frame_handler regression: fail");
    end
    $finish;
  end

endmodule
